>>> hdl/cpfr_pkg.sv
// shared types, constants and crc functions for the pose frame receiver
package cpfr_pkg;

  localparam int WORD_BYTES        = 12;
  localparam int PAYLOAD_BYTES_DEF = 12;
  localparam int READ_LIMIT_DEF    = 15;
  localparam int OUT_TDATA_W       = 104;
  localparam logic [15:0] ARC_POLY = 16'hA001;

  typedef enum logic [1:0] {
    ST_VALID   = 2'd0,
    ST_BAD_LEN = 2'd1,
    ST_BAD_CRC = 2'd2
  } status_t;

  typedef struct packed {
    logic [31:0] heading_bits;
    logic [31:0] pos_y_bits;
    logic [31:0] pos_x_bits;
    status_t     status;
  } result_t;

  // one byte through crc-16/arc, lsb first
  function automatic logic [15:0] crc_take(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ ARC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // keep both crc bytes nonzero so neither can look like a terminator
  function automatic logic [15:0] crc_adjust(logic [15:0] crc);
    logic [15:0] c;
    c = crc;
    if (c[15:8] == 8'h00) c[8] = 1'b1;
    if (c[7:0] == 8'h00) c[0] = 1'b1;
    return c;
  endfunction

endpackage

>>> hdl/cpfr_in_reg.sv
// input register stage for received bytes
module cpfr_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  output logic       byte_valid,
  output logic [7:0] byte_data,
  input  logic       take
);

  logic       valid_r;
  logic [7:0] data_r;

  assign in_tready  = !valid_r || take;
  assign byte_valid = valid_r;
  assign byte_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      data_r <= in_tdata;
    end
  end

endmodule

>>> hdl/cpfr_frame.sv
// frame state, crc check and result register
module cpfr_frame #(
  parameter int PAYLOAD_BYTES = cpfr_pkg::PAYLOAD_BYTES_DEF,
  parameter int READ_LIMIT    = cpfr_pkg::READ_LIMIT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_valid,
  input  logic [7:0]        byte_data,
  output logic              take,
  output logic              res_valid,
  input  logic              res_ready,
  output cpfr_pkg::result_t res
);

  localparam int CW = $clog2(READ_LIMIT + 1);

  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic [15:0]       rxcrc_r, rxcrc_nxt;
  logic [7:0]        store_r   [cpfr_pkg::WORD_BYTES];
  logic [7:0]        store_nxt [cpfr_pkg::WORD_BYTES];
  logic              frame_end;
  logic              res_valid_r;
  cpfr_pkg::result_t res_r, res_nxt;

  assign take      = !res_valid_r || res_ready;
  assign res_valid = res_valid_r;
  assign res       = res_r;

  always_comb begin
    store_nxt = store_r;
    crc_nxt   = crc_r;
    rxcrc_nxt = rxcrc_r;
    cnt_nxt   = cnt_r;
    frame_end = 1'b0;
    if (byte_data == 8'h00) begin
      frame_end = 1'b1;
    end else begin
      for (int k = 0; k < cpfr_pkg::WORD_BYTES; k++) begin
        if (32'(cnt_r) == 32'(k)) store_nxt[k] = byte_data;
      end
      if (32'(cnt_r) < 32'(PAYLOAD_BYTES)) begin
        crc_nxt = cpfr_pkg::crc_take(crc_r, byte_data);
      end else if (32'(cnt_r) == 32'(PAYLOAD_BYTES)) begin
        rxcrc_nxt[7:0] = byte_data;
      end else if (32'(cnt_r) == 32'(PAYLOAD_BYTES + 1)) begin
        rxcrc_nxt[15:8] = byte_data;
      end
      cnt_nxt   = cnt_r + CW'(1);
      frame_end = 32'(cnt_nxt) >= 32'(READ_LIMIT);
    end
  end

  always_comb begin
    res_nxt = '0;
    if (32'(cnt_nxt) != 32'(PAYLOAD_BYTES + 2)) begin
      res_nxt.status = cpfr_pkg::ST_BAD_LEN;
    end else if (cpfr_pkg::crc_adjust(crc_nxt) != rxcrc_nxt) begin
      res_nxt.status = cpfr_pkg::ST_BAD_CRC;
    end else begin
      res_nxt.status       = cpfr_pkg::ST_VALID;
      res_nxt.pos_x_bits   = {store_nxt[3], store_nxt[2], store_nxt[1], store_nxt[0]};
      res_nxt.pos_y_bits   = {store_nxt[7], store_nxt[6], store_nxt[5], store_nxt[4]};
      res_nxt.heading_bits = {store_nxt[11], store_nxt[10], store_nxt[9], store_nxt[8]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      crc_r       <= '0;
      res_valid_r <= 1'b0;
    end else if (take) begin
      res_valid_r <= byte_valid && frame_end;
      if (byte_valid) begin
        cnt_r <= frame_end ? '0 : cnt_nxt;
        crc_r <= frame_end ? '0 : crc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && byte_valid) begin
      store_r <= store_nxt;
      rxcrc_r <= rxcrc_nxt;
      if (frame_end) res_r <= res_nxt;
    end
  end

  a_cnt_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) < 32'(READ_LIMIT))
    else $error("byte count reached read limit without a frame end");

  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    take && byte_valid && frame_end |=> cnt_r == '0 && crc_r == '0)
    else $error("frame state not cleared after frame end");

  a_words_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && res_r.status != cpfr_pkg::ST_VALID |->
      res_r.pos_x_bits == '0 && res_r.pos_y_bits == '0 && res_r.heading_bits == '0)
    else $error("payload words nonzero on a failed frame");

  a_result_only_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    take && !(byte_valid && frame_end) |=> !res_valid_r)
    else $error("result raised without a frame end");

endmodule

>>> hdl/crc_checked_pose_frame_receiver.sv
// top level of the crc checked pose frame receiver
//
//  channel  | ports                    | payload
//  ---------+--------------------------+------------------------------------
//  input    | in_tvalid/tready/tdata   | one received byte
//  result   | out_tvalid/tready/tdata  | status and three 32-bit pose words
//
// one byte is taken per cycle while the result channel is not stalled; out_tvalid for
// a frame rises after its ending byte passes the input register, then the result register.
// the byte crc is one unrolled 8-step xor network in the frame stage.
// rst_n is synchronous and clears the frame count, crc and both valid flags.
// a stalled result blocks only once the input register is also full.
module crc_checked_pose_frame_receiver #(
  parameter int PAYLOAD_BYTES = cpfr_pkg::PAYLOAD_BYTES_DEF,
  parameter int READ_LIMIT    = cpfr_pkg::READ_LIMIT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] rx_byte
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [1:0] status, [33:2] pos_x_bits, [65:34] pos_y_bits,
  // [97:66] heading_bits, [103:98] zero
  output logic [cpfr_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic              byte_valid;
  logic [7:0]        byte_data;
  logic              take;
  cpfr_pkg::result_t res;

  cpfr_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .take       (take)
  );

  cpfr_frame #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES),
    .READ_LIMIT    (READ_LIMIT)
  ) u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .take       (take),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res)
  );

  assign out_tdata = {6'b000000, res.heading_bits, res.pos_y_bits, res.pos_x_bits,
                      res.status};

endmodule

>>> dv/crc_checked_pose_frame_receiver_test.sv
// self-checking stream testbench for the crc checked pose frame receiver
module crc_checked_pose_frame_receiver_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_LEN   = cpfr_pkg::PAYLOAD_BYTES_DEF + 2;
  localparam int PHASE_BYTES = 225;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 8;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
  typedef enum int {PK_ANY, PK_HI_ZERO, PK_LO_ZERO, PK_ZERO} payload_kind_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [7:0]                       in_tdata = 8'h00;   // [7:0] rx_byte
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  // [1:0] status, [33:2] pos_x_bits, [65:34] pos_y_bits, [97:66] heading_bits
  logic [cpfr_pkg::OUT_TDATA_W-1:0] out_tdata;

  logic [7:0]         rx_pending[$];
  cpfr_pkg::result_t  pose_expect[$];
  idle_mode_t         idle_mode = IDLE_NONE;
  int                 bytes_queued = 0;
  int                 bytes_sent = 0;
  int                 mismatches = 0;
  int                 n_valid = 0, n_bad_len = 0, n_bad_crc = 0;
  int                 corner_frames = 0;
  int                 hold_left = 0;
  bit                 hold_done = 1'b0;
  int                 quiet_cycles = 0;

  // predictor state
  logic [7:0]  frame_store[cpfr_pkg::WORD_BYTES];
  int          frame_fill = 0;
  logic [15:0] crc_acc = 16'h0000;
  logic [15:0] crc_rx = 16'h0000;

  crc_checked_pose_frame_receiver dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  // bit-serial crc-16/arc, lsb first
  function automatic logic [15:0] arc_step(logic [15:0] acc, logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb  = acc[0] ^ b[i];
      acc = acc >> 1;
      if (fb) acc = acc ^ cpfr_pkg::ARC_POLY;
    end
    return acc;
  endfunction

  function automatic logic [15:0] arc_over(logic [95:0] p, int n);
    logic [15:0] acc;
    acc = 16'h0000;
    for (int i = 0; i < n; i++) acc = arc_step(acc, p[8*i +: 8]);
    return acc;
  endfunction

  // neither crc byte may be zero on the wire
  function automatic logic [15:0] crc_no_zero_bytes(logic [15:0] c);
    if (c[15:8] == 8'h00) c[8] = 1'b1;
    if (c[7:0] == 8'h00) c[0] = 1'b1;
    return c;
  endfunction

  function automatic bit roll(int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic logic [95:0] make_payload(payload_kind_t kind);
    logic [95:0] p;
    logic [15:0] c;
    int          tries;
    tries = 0;
    forever begin
      for (int i = 0; i < cpfr_pkg::WORD_BYTES; i++) p[8*i +: 8] = 8'($urandom_range(255, 1));
      tries++;
      c = arc_over(p, cpfr_pkg::WORD_BYTES);
      case (kind)
        PK_HI_ZERO: if (c[15:8] == 8'h00 || tries > 20000) return p;
        PK_LO_ZERO: if ((c[7:0] == 8'h00 && c[15:8] != 8'h00) || tries > 20000) return p;
        PK_ZERO: begin
          // appending the crc of the first ten bytes leaves a zero residue
          c = arc_over(p, cpfr_pkg::WORD_BYTES - 2);
          if (c[7:0] != 8'h00 && c[15:8] != 8'h00) begin
            p[8*(cpfr_pkg::WORD_BYTES-2) +: 8] = c[7:0];
            p[8*(cpfr_pkg::WORD_BYTES-1) +: 8] = c[15:8];
            return p;
          end
        end
        default: return p;
      endcase
    end
  endfunction

  task automatic queue_byte(logic [7:0] b);
    rx_pending = {rx_pending, b};
    bytes_queued++;
  endtask

  // payload, crc low then high, terminator; a corrupt crc stays nonzero
  task automatic queue_frame(logic [95:0] p, bit corrupt);
    logic [15:0] c;
    logic [7:0]  flip;
    c = crc_no_zero_bytes(arc_over(p, cpfr_pkg::WORD_BYTES));
    if (corrupt) begin
      do flip = 8'($urandom_range(255, 1));
      while ((c[7:0] ^ flip) == 8'h00 || (c[15:8] ^ flip) == 8'h00);
      if (roll(50)) c[7:0] = c[7:0] ^ flip;
      else c[15:8] = c[15:8] ^ flip;
    end
    for (int i = 0; i < cpfr_pkg::WORD_BYTES; i++) queue_byte(p[8*i +: 8]);
    queue_byte(c[7:0]);
    queue_byte(c[15:8]);
    queue_byte(8'h00);
  endtask

  task automatic queue_random_frame();
    int            pick, len;
    payload_kind_t kind;
    pick = $urandom_range(99);
    if (pick < 60) begin
      case ($urandom_range(19))
        0: kind = PK_HI_ZERO;
        1: kind = PK_LO_ZERO;
        2: kind = PK_ZERO;
        default: kind = PK_ANY;
      endcase
      if (kind != PK_ANY) corner_frames++;
      queue_frame(make_payload(kind), 1'b0);
    end else if (pick < 72) begin
      queue_frame(make_payload(PK_ANY), 1'b1);
    end else if (pick < 82) begin
      // short or one byte too long before the terminator
      len = $urandom_range(FRAME_LEN + 1, 1);
      if (len == FRAME_LEN) len = 1;
      for (int i = 0; i < len; i++) queue_byte(8'($urandom_range(255, 1)));
      queue_byte(8'h00);
    end else if (pick < 90) begin
      // no terminator: ends at the read limit
      for (int i = 0; i < cpfr_pkg::READ_LIMIT_DEF; i++)
        queue_byte(8'($urandom_range(255, 1)));
    end else if (pick < 95) begin
      queue_byte(8'h00);
    end else begin
      len = $urandom_range(6, 1);
      for (int i = 0; i < len; i++) queue_byte(8'($urandom_range(255)));
    end
  endtask

  // predictor: one accepted byte, at most one pose result
  task automatic absorb_byte(logic [7:0] b);
    bit                ends;
    cpfr_pkg::result_t r;
    ends = 1'b0;
    if (b == 8'h00) begin
      ends = 1'b1;
    end else begin
      if (frame_fill < cpfr_pkg::WORD_BYTES) frame_store[frame_fill] = b;
      if (frame_fill < cpfr_pkg::PAYLOAD_BYTES_DEF) crc_acc = arc_step(crc_acc, b);
      else if (frame_fill == cpfr_pkg::PAYLOAD_BYTES_DEF) crc_rx[7:0] = b;
      else if (frame_fill == cpfr_pkg::PAYLOAD_BYTES_DEF + 1) crc_rx[15:8] = b;
      frame_fill++;
      ends = frame_fill >= cpfr_pkg::READ_LIMIT_DEF;
    end
    if (ends) begin
      r = '0;
      if (frame_fill != FRAME_LEN) begin
        r.status = cpfr_pkg::ST_BAD_LEN;
      end else if (crc_no_zero_bytes(crc_acc) != crc_rx) begin
        r.status = cpfr_pkg::ST_BAD_CRC;
      end else begin
        r.status       = cpfr_pkg::ST_VALID;
        r.pos_x_bits   = {frame_store[3], frame_store[2], frame_store[1], frame_store[0]};
        r.pos_y_bits   = {frame_store[7], frame_store[6], frame_store[5], frame_store[4]};
        r.heading_bits = {frame_store[11], frame_store[10], frame_store[9], frame_store[8]};
      end
      pose_expect = {pose_expect, r};
      frame_fill = 0;
      crc_acc    = 16'h0000;
    end
  endtask

  task automatic flag_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : byte_driver
    bit gap;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'h00;
    end else begin
      if (in_tvalid && in_tready) begin
        absorb_byte(in_tdata);
        void'(rx_pending.pop_front());
        bytes_sent <= bytes_sent + 1;
      end
      if (!(in_tvalid && !in_tready)) begin
        gap = (idle_mode == IDLE_SENDER && roll(53)) || (idle_mode == IDLE_BOTH && roll(20));
        if (rx_pending.size() != 0 && !gap) begin
          in_tvalid <= 1'b1;
          in_tdata  <= rx_pending[0];
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : pose_monitor
    cpfr_pkg::result_t want;
    bit                stall;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pose_expect.size() == 0) begin
          $display("%0t: unexpected result transfer, expected none got %h", $time, out_tdata);
          mismatches++;
        end else begin
          want = pose_expect.pop_front();
          flag_field("status", 32'(want.status), 32'(out_tdata[1:0]));
          flag_field("pos_x_bits", want.pos_x_bits, out_tdata[33:2]);
          flag_field("pos_y_bits", want.pos_y_bits, out_tdata[65:34]);
          flag_field("heading_bits", want.heading_bits, out_tdata[97:66]);
          case (want.status)
            cpfr_pkg::ST_VALID:   n_valid++;
            cpfr_pkg::ST_BAD_LEN: n_bad_len++;
            default:              n_bad_crc++;
          endcase
        end
      end
      // one long hold-off while bytes keep coming, so the input backs up
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        stall = 1'b1;
      end else if (!hold_done && idle_mode == IDLE_NONE && bytes_sent >= 60) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
        stall = 1'b1;
      end else begin
        stall = (idle_mode == IDLE_RECEIVER && roll(53)) || (idle_mode == IDLE_BOTH && roll(20));
      end
      out_tready <= !stall;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int phase_end;
    @(posedge rst_n);
    for (int ph = 0; ph < 4; ph++) begin
      @(negedge clk);
      idle_mode = idle_mode_t'(ph);
      if (ph == 0) begin
        queue_byte(8'h00);                                       // empty frame
        queue_frame({cpfr_pkg::WORD_BYTES{8'hFF}}, 1'b0);        // all-ones payload
        queue_byte(8'h01);
        queue_byte(8'h00);                                       // short frame
        for (int i = 0; i < cpfr_pkg::READ_LIMIT_DEF; i++)       // frame at the read limit
          queue_byte(i[0] ? 8'hAA : 8'h55);
      end
      phase_end = bytes_queued + PHASE_BYTES;
      while (bytes_queued < phase_end) queue_random_frame();
      while (rx_pending.size() != 0 || pose_expect.size() != 0) @(negedge clk);
    end
    repeat (DRAIN_WAIT) @(negedge clk);
    if (pose_expect.size() != 0) begin
      $display("%0t: results missing, expected %0d more got 0", $time, pose_expect.size());
      mismatches++;
    end
    $display("sent %0d bytes over four idle patterns, %0d crc corner payloads",
             bytes_sent, corner_frames);
    $display("frames checked: %0d valid, %0d wrong length, %0d crc mismatch",
             n_valid, n_bad_len, n_bad_crc);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
